// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, held off during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== hw/rtl/klt_pkg.sv =====
// types, constants and character classes of the keyword lexer
`timescale 1ns / 1ps

package klt_pkg;

    localparam int MAX_TEXT_BYTES = 65536;
    localparam logic [15:0] POS_CAP = ((MAX_TEXT_BYTES - 1) < 65535) ?
                                      16'(MAX_TEXT_BYTES - 1) : 16'hFFFF;

    localparam int NUM_KW = 13;
    localparam int KW_CHARS = 9;

    // token kinds
    localparam logic [4:0] KIND_EOF     = 5'd0;
    localparam logic [4:0] KIND_INT     = 5'd1;
    localparam logic [4:0] KIND_IDENT   = 5'd2;
    localparam logic [4:0] KIND_STRING  = 5'd3;
    localparam logic [4:0] KIND_KW_BASE = 5'd4;
    localparam logic [4:0] KIND_ASSIGN  = 5'd17;
    localparam logic [4:0] KIND_COMMA   = 5'd18;
    localparam logic [4:0] KIND_COLON   = 5'd19;
    localparam logic [4:0] KIND_SEMI    = 5'd20;
    localparam logic [4:0] KIND_LPAREN  = 5'd21;
    localparam logic [4:0] KIND_RPAREN  = 5'd22;
    localparam logic [4:0] KIND_LBRACE  = 5'd23;
    localparam logic [4:0] KIND_RBRACE  = 5'd24;
    localparam logic [4:0] KIND_LBRACK  = 5'd25;
    localparam logic [4:0] KIND_RBRACK  = 5'd26;
    localparam logic [4:0] KIND_BAD     = 5'd27;
    localparam logic [4:0] KIND_UNTERM  = 5'd28;
    localparam logic [4:0] KIND_NONE    = 5'd0;

    // characters with a role of their own
    localparam logic [7:0] CHR_NUL    = 8'h00;
    localparam logic [7:0] CHR_QUOTE  = 8'h22;
    localparam logic [7:0] CHR_SPACE  = 8'h20;
    localparam logic [7:0] CHR_TAB    = 8'h09;
    localparam logic [7:0] CHR_CR     = 8'h0D;
    localparam logic [7:0] CHR_LF     = 8'h0A;

    localparam logic [NUM_KW-1:0] KW_ALL = '1;

    // keyword text, right justified: last character in bits 7:0
    localparam logic [8*KW_CHARS-1:0] KW_TEXT [NUM_KW] = '{
        72'("null"), 72'("undefined"), 72'("true"), 72'("false"), 72'("if"),
        72'("else"), 72'("while"), 72'("break"), 72'("continue"),
        72'("function"), 72'("const"), 72'("type"), 72'("record")
    };
    localparam logic [3:0] KW_LEN [NUM_KW] = '{
        4'd4, 4'd9, 4'd4, 4'd5, 4'd2, 4'd4, 4'd5, 4'd5, 4'd8, 4'd8, 4'd5, 4'd4, 4'd6
    };

    // result queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] start;
        logic [15:0] length;
        logic        last;
    } token_t;

    // what one scanned byte hands to the queue
    typedef struct packed {
        logic [1:0] count;
        token_t     tok0;
        token_t     tok1;
    } scan_out_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CHR_SPACE) || (c == CHR_TAB) || (c == CHR_CR) || (c == CHR_LF);
    endfunction

    function automatic logic is_num(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_num(c) || ((c >= 8'h41) && (c <= 8'h5A)) ||
               ((c >= 8'h61) && (c <= 8'h7A)) || (c == 8'h5F);
    endfunction

    function automatic logic [4:0] punct_kind(input logic [7:0] c);
        logic [4:0] k;
        case (c)
            8'h3D:   k = KIND_ASSIGN;
            8'h2C:   k = KIND_COMMA;
            8'h3A:   k = KIND_COLON;
            8'h3B:   k = KIND_SEMI;
            8'h28:   k = KIND_LPAREN;
            8'h29:   k = KIND_RPAREN;
            8'h7B:   k = KIND_LBRACE;
            8'h7D:   k = KIND_RBRACE;
            8'h5B:   k = KIND_LBRACK;
            8'h5D:   k = KIND_RBRACK;
            default: k = KIND_NONE;
        endcase
        return k;
    endfunction

    // drop keywords whose character at index wl differs from c
    function automatic logic [NUM_KW-1:0] mask_update(input logic [NUM_KW-1:0] mask,
                                                      input logic [3:0] wl,
                                                      input logic [7:0] c);
        logic [NUM_KW-1:0] m;
        logic [3:0]        sh;
        logic [7:0]        ch;
        m = mask;
        for (int k = 0; k < NUM_KW; k++) begin
            sh = KW_LEN[k] - 4'd1 - wl;
            ch = KW_TEXT[k][8*sh +: 8];
            if (!((wl < KW_LEN[k]) && (ch == c))) begin
                m[k] = 1'b0;
            end
        end
        return m;
    endfunction

    // first keyword still matching whose length equals the word length
    function automatic logic [4:0] ident_kind(input logic [NUM_KW-1:0] mask,
                                              input logic [3:0] wl);
        logic [4:0] kind;
        kind = KIND_IDENT;
        for (int k = NUM_KW - 1; k >= 0; k--) begin
            if (mask[k] && (wl == KW_LEN[k])) begin
                kind = KIND_KW_BASE + 5'(k);
            end
        end
        return kind;
    endfunction

endpackage

// ===== hw/rtl/klt_scan.sv =====
// scanner state and the per-byte token logic
`timescale 1ns / 1ps

module klt_scan (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [7:0]         in_char,
    output klt_pkg::scan_out_t result
);
    import klt_pkg::*;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_INT    = 3'd1,
        MODE_IDENT  = 3'd2,
        MODE_STRING = 3'd3,
        MODE_DROP   = 3'd4
    } mode_t;

    mode_t             mode_reg, mode_next;
    logic [15:0]       pos_reg, pos_next;
    logic [15:0]       start_reg, start_next;
    logic [NUM_KW-1:0] mask_reg, mask_next;
    logic [3:0]        wl_reg, wl_next;

    // opening a new token at the current byte
    mode_t             open_mode;
    logic              open_emit;
    token_t            open_tok;
    logic              open_start;
    logic              open_word;

    // closing the token in progress
    logic              close_emit;
    token_t            close_tok;
    logic              do_open;

    logic [15:0]       span;
    logic [16:0]       str_len;

    assign span    = pos_reg - start_reg;
    assign str_len = {1'b0, span} + 17'd1;

    always_comb
    begin
        open_mode  = MODE_IDLE;
        open_emit  = 1'b0;
        open_start = 1'b0;
        open_word  = 1'b0;
        open_tok   = '{kind: KIND_EOF, start: pos_reg, length: 16'd0, last: 1'b0};
        if (in_char == CHR_NUL) begin
            open_emit = 1'b1;
        end
        else if (is_blank(in_char)) begin
            open_mode = MODE_IDLE;
        end
        else if (is_num(in_char)) begin
            open_mode  = MODE_INT;
            open_start = 1'b1;
        end
        else if (is_word(in_char)) begin
            open_mode  = MODE_IDENT;
            open_start = 1'b1;
            open_word  = 1'b1;
        end
        else if (in_char == CHR_QUOTE) begin
            open_mode  = MODE_STRING;
            open_start = 1'b1;
        end
        else if (punct_kind(in_char) != KIND_NONE) begin
            open_emit       = 1'b1;
            open_tok.kind   = punct_kind(in_char);
            open_tok.length = 16'd1;
        end
        else begin
            open_emit       = 1'b1;
            open_mode       = MODE_DROP;
            open_tok.kind   = KIND_BAD;
            open_tok.length = 16'd1;
        end
    end

    always_comb
    begin
        mode_next  = mode_reg;
        start_next = start_reg;
        mask_next  = mask_reg;
        wl_next    = wl_reg;
        close_emit = 1'b0;
        close_tok  = '{kind: KIND_INT, start: start_reg, length: span, last: 1'b0};
        do_open    = 1'b0;

        unique case (mode_reg)
            MODE_INT:
            begin
                if (!is_num(in_char)) begin
                    close_emit = 1'b1;
                    do_open    = 1'b1;
                end
            end
            MODE_IDENT:
            begin
                if (is_word(in_char)) begin
                    mask_next = mask_update(mask_reg, wl_reg, in_char);
                    wl_next   = (wl_reg == 4'hF) ? wl_reg : wl_reg + 4'd1;
                end
                else begin
                    close_emit     = 1'b1;
                    close_tok.kind = ident_kind(mask_reg, wl_reg);
                    do_open        = 1'b1;
                end
            end
            MODE_STRING:
            begin
                if (in_char == CHR_QUOTE) begin
                    close_emit       = 1'b1;
                    close_tok.kind   = KIND_STRING;
                    close_tok.length = str_len[16] ? 16'hFFFF : str_len[15:0];
                    mode_next        = MODE_IDLE;
                end
                else if (in_char == CHR_NUL) begin
                    close_emit     = 1'b1;
                    close_tok.kind = KIND_UNTERM;
                    mode_next      = MODE_IDLE;
                end
            end
            MODE_DROP:
            begin
                if (in_char == CHR_NUL) begin
                    mode_next = MODE_IDLE;
                end
            end
            MODE_IDLE:
            begin
                do_open = 1'b1;
            end
            default:
            begin
                mode_next = MODE_IDLE;
            end
        endcase

        if (do_open) begin
            mode_next = open_mode;
            if (open_start) begin
                start_next = pos_reg;
            end
            if (open_word) begin
                mask_next = mask_update(KW_ALL, 4'd0, in_char);
                wl_next   = 4'd1;
            end
        end

        if (in_char == CHR_NUL) begin
            pos_next = 16'd0;
        end
        else if (pos_reg < POS_CAP) begin
            pos_next = pos_reg + 16'd1;
        end
        else begin
            pos_next = POS_CAP;
        end
    end

    // pack up to two tokens, the final one flagged
    always_comb
    begin
        result.tok0 = close_emit ? close_tok : open_tok;
        result.tok1 = open_tok;
        if (close_emit && do_open && open_emit) begin
            result.count     = 2'd2;
            result.tok0.last = 1'b0;
            result.tok1.last = 1'b1;
        end
        else if (close_emit || (do_open && open_emit)) begin
            result.count     = 2'd1;
            result.tok0.last = 1'b1;
        end
        else begin
            result.count = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg  <= MODE_IDLE;
            pos_reg   <= 16'd0;
            start_reg <= 16'd0;
            mask_reg  <= KW_ALL;
            wl_reg    <= 4'd0;
        end
        else if (step) begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            mask_reg  <= mask_next;
            wl_reg    <= wl_next;
        end
    end

endmodule

// ===== hw/rtl/klt_queue.sv =====
// small result queue taking up to two tokens a cycle and giving one
`timescale 1ns / 1ps

module klt_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  klt_pkg::scan_out_t push_data,
    input  logic               pop,
    output logic               not_empty,
    output logic               room_for_two,
    output klt_pkg::token_t    head
);
    import klt_pkg::*;

    token_t              entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic [QPTR_W-1:0]   wr_ptr_plus1;
    logic [QCNT_W-1:0]   push_n;

    assign wr_ptr_plus1 = wr_ptr_reg + QPTR_W'(1);
    assign push_n       = push ? QCNT_W'(push_data.count) : '0;
    assign not_empty    = (count_reg != '0);
    assign room_for_two = (count_reg <= QCNT_W'(QUEUE_DEPTH - 2));
    assign head         = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push_n);
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + push_n - (pop ? QCNT_W'(1) : '0);
    end

    always_ff @(posedge clk)
    begin
        if (push && (push_data.count != 2'd0)) begin
            entries_reg[wr_ptr_reg] <= push_data.tok0;
        end
        if (push && (push_data.count == 2'd2)) begin
            entries_reg[wr_ptr_plus1] <= push_data.tok1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hw/rtl/keyword_lexer_tokenizer.sv =====
// top level of the streaming keyword lexer
// ---------------------------------------------------------------------------
// input channel: in_valid / in_stall carry one source byte per word on in_byte;
//   a zero byte ends the current text and restarts offsets at zero
// output channel: out_valid / out_stall carry one token per word: token_kind,
//   token_start, token_length and last_result, which marks the final token
//   that a given byte caused (a byte causes zero, one or two tokens)
// path: a byte taken goes to the input register and is scanned from there;
//   the scan step pushes its tokens into the result queue, which drives the output
// throughput: one byte per cycle while the receiver keeps up; a byte that
//   causes two tokens needs two output words, so the output side sets the
//   pace then
// the scan step runs only when the four-entry result queue has room for two
//   tokens; otherwise the byte waits in the input register and in_stall rises
// when the receiver stalls, the queue fills and the input stalls in turn;
//   nothing is lost and a stalled output word holds still
// reset: queue empty, input register empty, scanner between tokens at
//   offset zero with every keyword still a candidate
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module keyword_lexer_tokenizer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [4:0]  token_kind,
    output logic [15:0] token_start,
    output logic [15:0] token_length,
    output logic        last_result
);
    import klt_pkg::*;

    // input register: one byte waiting to be scanned
    logic       in_full_reg, in_full_next;
    logic [7:0] in_byte_reg;

    logic       in_take;
    logic       step;
    logic       room_for_two;
    logic       not_empty;
    logic       pop;
    scan_out_t  scan_result;
    token_t     head;

    // scan only when the queue can absorb the worst case of two tokens
    assign step     = in_full_reg && room_for_two;
    assign in_stall = in_full_reg && !room_for_two;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        if (in_take) begin
            in_full_next = 1'b1;
        end
        else if (step) begin
            in_full_next = 1'b0;
        end
        else begin
            in_full_next = in_full_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_full_reg <= 1'b0;
        end
        else begin
            in_full_reg <= in_full_next;
        end
    end

    // byte payload needs no reset
    always_ff @(posedge clk)
    begin
        if (in_take) begin
            in_byte_reg <= in_byte;
        end
    end

    // per-byte classification, keyword mask and token building
    klt_scan u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .in_char (in_byte_reg),
        .result  (scan_result)
    );

    // tokens wait here until the receiver takes them
    assign pop = not_empty && !out_stall;

    klt_queue u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (step),
        .push_data    (scan_result),
        .pop          (pop),
        .not_empty    (not_empty),
        .room_for_two (room_for_two),
        .head         (head)
    );

    assign out_valid    = not_empty;
    assign token_kind   = head.kind;
    assign token_start  = head.start;
    assign token_length = head.length;
    assign last_result  = head.last;

endmodule

// ===== hw/rtl/klt_checker.sv =====
// port-level checks of the keyword lexer, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module klt_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  in_byte,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [4:0]  token_kind,
    input  logic [15:0] token_start,
    input  logic [15:0] token_length,
    input  logic        last_result
);
    import klt_pkg::*;

    // end of text is empty and always the final token of its byte
    `ASSERT_IMPLIES(a_eof_shape, clk, rst_n,
        out_valid && (token_kind == KIND_EOF),
        (token_length == 16'd0) && last_result)

    // punctuators and bad characters are one byte long and end their byte
    `ASSERT_IMPLIES(a_single_char, clk, rst_n,
        out_valid && (token_kind >= KIND_ASSIGN) && (token_kind <= KIND_BAD),
        (token_length == 16'd1) && last_result)

    // a closed string is never empty, even once offsets stop growing
    `ASSERT_IMPLIES(a_string_len, clk, rst_n,
        out_valid && (token_kind == KIND_STRING),
        token_length != 16'd0)

    // a stalled input word holds still
    `ASSERT_NEXT(a_in_hold, clk, rst_n,
        in_valid && in_stall,
        in_valid && $stable(in_byte))

    // a stalled output word holds still
    `ASSERT_NEXT(a_out_hold, clk, rst_n,
        out_valid && out_stall,
        out_valid && $stable(token_kind) && $stable(token_start) &&
        $stable(token_length) && $stable(last_result))

endmodule

bind keyword_lexer_tokenizer klt_checker u_klt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .token_kind   (token_kind),
    .token_start  (token_start),
    .token_length (token_length),
    .last_result  (last_result)
);

// ===== bench/tb_keyword_lexer_tokenizer.sv =====
// self-checking testbench for the keyword lexer: byte stimulus, token predictor, scoreboard
`timescale 1ns / 1ps

module tb_keyword_lexer_tokenizer;

    import klt_pkg::*;

    // watchdog limit on cycles with no word moving on either channel
    localparam int QUIET_LIMIT = 5000;
    // length of the long receiver hold-off in the backpressure test
    localparam int HOLD_CYCLES = 300;
    // cycles to linger after the last token
    localparam int TAIL_CYCLES = 10;

    // scanner states of the predictor
    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_INT,
        SCAN_WORD,
        SCAN_STR,
        SCAN_DROP
    } scan_state_t;

    // one expected token
    typedef struct {
        logic [4:0]  kind;
        logic [15:0] start;
        logic [15:0] len;
        logic        last;
    } token_exp_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  in_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [4:0]  token_kind;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic        last_result;

    keyword_lexer_tokenizer u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_byte      (in_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .token_kind   (token_kind),
        .token_start  (token_start),
        .token_length (token_length),
        .last_result  (last_result)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // keyword spellings in kind order, kind = KIND_KW_BASE + index
    string kw_names [NUM_KW] = '{
        "null", "undefined", "true", "false", "if", "else", "while",
        "break", "continue", "function", "const", "type", "record"
    };
    string punct_chars = "=,:;(){}[]";

    // predictor state, mirrors the scanner registers
    scan_state_t       lex_mode;
    logic [15:0]       text_pos;
    logic [15:0]       tok_start;
    logic [NUM_KW-1:0] kw_cand;
    logic [3:0]        word_len;

    // tokens still owed by the block, oldest first
    token_exp_t pending_tokens [$];
    // tokens caused by the byte being predicted
    token_exp_t step_tokens [$];
    token_exp_t oldest;

    int mismatches = 0;
    int sent_bytes = 0;       // bytes accepted by the block so far
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    // ------------------------------------------------------------------
    // character classes
    // ------------------------------------------------------------------
    function automatic bit is_space_chr(input logic [7:0] c);
        return c == CHR_SPACE || c == CHR_TAB || c == CHR_CR || c == CHR_LF;
    endfunction

    function automatic bit is_digit_chr(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_word_chr(input logic [7:0] c);
        return is_digit_chr(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
               c == "_";
    endfunction

    function automatic logic [4:0] punct_of(input logic [7:0] c);
        case (c)
            "=":     return KIND_ASSIGN;
            ",":     return KIND_COMMA;
            ":":     return KIND_COLON;
            ";":     return KIND_SEMI;
            "(":     return KIND_LPAREN;
            ")":     return KIND_RPAREN;
            "{":     return KIND_LBRACE;
            "}":     return KIND_RBRACE;
            "[":     return KIND_LBRACK;
            "]":     return KIND_RBRACK;
            default: return KIND_NONE;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // token predictor
    // ------------------------------------------------------------------
    function automatic void lex_reset();
        lex_mode  = SCAN_IDLE;
        text_pos  = '0;
        tok_start = '0;
        kw_cand   = KW_ALL;
        word_len  = '0;
    endfunction

    // lengths saturate at the 16-bit field
    function automatic void emit_token(input logic [4:0] kind, input int start, input int len);
        token_exp_t t;
        t.kind  = kind;
        t.start = 16'(start);
        t.len   = (len > 65535) ? 16'hFFFF : 16'(len);
        t.last  = 1'b0;
        step_tokens.push_back(t);
    endfunction

    // strike keywords whose character at the current index differs
    function automatic void narrow_keywords(input logic [7:0] c);
        for (int k = 0; k < NUM_KW; k++) begin
            if (!(word_len < kw_names[k].len() && 8'(kw_names[k][word_len]) == c))
                kw_cand[k] = 1'b0;
        end
        if (word_len < 4'd15)
            word_len = word_len + 4'd1;
    endfunction

    // lowest surviving keyword of exactly this length, else a plain identifier
    function automatic logic [4:0] word_kind();
        for (int k = 0; k < NUM_KW; k++) begin
            if (kw_cand[k] && word_len == kw_names[k].len())
                return KIND_KW_BASE + 5'(k);
        end
        return KIND_IDENT;
    endfunction

    // byte seen while no token is open
    function automatic void open_token(input logic [7:0] c);
        logic [4:0] pk;
        pk = punct_of(c);
        if (c == CHR_NUL) begin
            emit_token(KIND_EOF, text_pos, 0);
            lex_mode = SCAN_IDLE;
        end else if (is_space_chr(c)) begin
            lex_mode = SCAN_IDLE;
        end else if (is_digit_chr(c)) begin
            tok_start = text_pos;
            lex_mode  = SCAN_INT;
        end else if (is_word_chr(c)) begin
            tok_start = text_pos;
            kw_cand   = KW_ALL;
            word_len  = '0;
            narrow_keywords(c);
            lex_mode  = SCAN_WORD;
        end else if (c == CHR_QUOTE) begin
            tok_start = text_pos;
            lex_mode  = SCAN_STR;
        end else if (pk != KIND_NONE) begin
            emit_token(pk, text_pos, 1);
            lex_mode = SCAN_IDLE;
        end else begin
            emit_token(KIND_BAD, text_pos, 1);
            lex_mode = SCAN_DROP;
        end
    endfunction

    // advance the predictor by one accepted byte and queue its tokens
    function automatic void lex_byte(input logic [7:0] c);
        int span;
        step_tokens.delete();
        span = int'(text_pos) - int'(tok_start);
        sent_bytes++;
        case (lex_mode)
            SCAN_INT: begin
                if (!is_digit_chr(c)) begin
                    emit_token(KIND_INT, tok_start, span);
                    open_token(c);
                end
            end
            SCAN_WORD: begin
                if (c != CHR_NUL && is_word_chr(c)) begin
                    narrow_keywords(c);
                end else begin
                    emit_token(word_kind(), tok_start, span);
                    open_token(c);
                end
            end
            SCAN_STR: begin
                if (c == CHR_QUOTE) begin
                    emit_token(KIND_STRING, tok_start, span + 1);
                    lex_mode = SCAN_IDLE;
                end else if (c == CHR_NUL) begin
                    emit_token(KIND_UNTERM, tok_start, span);
                    lex_mode = SCAN_IDLE;
                end
            end
            SCAN_DROP: begin
                if (c == CHR_NUL)
                    lex_mode = SCAN_IDLE;
            end
            default: open_token(c);
        endcase
        if (c == CHR_NUL)
            text_pos = '0;
        else if (text_pos < POS_CAP)
            text_pos = text_pos + 16'd1;
        if (step_tokens.size() > 0)
            step_tokens[step_tokens.size() - 1].last = 1'b1;
        foreach (step_tokens[i])
            pending_tokens.push_back(step_tokens[i]);
    endfunction

    // ------------------------------------------------------------------
    // input side: offer one byte, random gaps before it, predict on accept
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        // word moves at the first edge with in_stall low
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        lex_byte(b);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(8'(s[i]));
    endtask

    // stop offering and let every owed token come out
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_tokens.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // random byte helpers
    // ------------------------------------------------------------------
    function automatic logic [7:0] rand_letter();
        int r;
        r = $urandom_range(0, 52);
        if (r < 26)
            return 8'("a" + r);
        else if (r < 52)
            return 8'("A" + r - 26);
        return "_";
    endfunction

    function automatic logic [7:0] rand_word_chr();
        if ($urandom_range(0, 3) == 0)
            return 8'("0" + $urandom_range(0, 9));
        return rand_letter();
    endfunction

    // anything a string may hold: not zero, not a quote
    function automatic logic [7:0] rand_str_chr();
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (c == CHR_QUOTE);
        return c;
    endfunction

    function automatic logic [7:0] rand_blank();
        case ($urandom_range(0, 3))
            0:       return CHR_SPACE;
            1:       return CHR_TAB;
            2:       return CHR_CR;
            default: return CHR_LF;
        endcase
    endfunction

    // one text of well-formed tokens with some noise mixed in
    task automatic send_random_text();
        int    ntok;
        int    pick;
        int    n;
        string word_txt;
        ntok = $urandom_range(1, 10);
        repeat (ntok) begin
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                n = $urandom_range(1, 6);
                repeat (n) send_byte(8'("0" + $urandom_range(0, 9)));
            end else if (pick < 40) begin
                // keyword, now and then one letter short or one too many
                word_txt = kw_names[$urandom_range(0, NUM_KW - 1)];
                n = $urandom_range(0, 9);
                if (n == 0 && word_txt.len() > 1)
                    word_txt = word_txt.substr(0, word_txt.len() - 2);
                else if (n == 1)
                    word_txt = {word_txt, "s"};
                send_text(word_txt);
            end else if (pick < 55) begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 6);
                send_byte(rand_letter());
                repeat (n - 1) send_byte(rand_word_chr());
            end else if (pick < 65) begin
                send_byte(CHR_QUOTE);
                n = $urandom_range(0, 5);
                repeat (n) send_byte(rand_str_chr());
                send_byte(CHR_QUOTE);
            end else if (pick < 90) begin
                send_byte(8'(punct_chars[$urandom_range(0, 9)]));
            end else begin
                send_byte(8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 9) < 7)
                repeat ($urandom_range(1, 2)) send_byte(rand_blank());
        end
        // sometimes leave a string open at the end of the text
        if ($urandom_range(0, 9) == 0) begin
            send_byte(CHR_QUOTE);
            repeat ($urandom_range(0, 3)) send_byte(rand_str_chr());
        end
        send_byte(CHR_NUL);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // punctuators, strings, a few keywords and near misses
    task automatic test_tokens();
        send_text("x=12;(a,b):[c]{d}");
        send_byte(CHR_NUL);
        send_text("\"a b\"\"\" type undefined undefine nulls If");
        send_byte(CHR_NUL);
        wait_drained();
    endtask

    // empty text, bad characters, text closed inside a token
    task automatic test_errors();
        send_byte(CHR_NUL);
        send_text("ab@cd 7");
        send_byte(CHR_NUL);
        send_byte(8'hFF);
        send_text("x");
        send_byte(CHR_NUL);
        send_byte(8'h80);
        send_byte(CHR_NUL);
        send_text("42");
        send_byte(CHR_NUL);
        send_text("\"abc");
        send_byte(CHR_NUL);
        send_text("w");
        send_byte(CHR_NUL);
        wait_drained();
    endtask

    // the eight-letter keywords, a longer near miss, and a word too long for any keyword
    task automatic test_long_words();
        send_text("continue function functions abcdefghijklmnopqrstuvw x_9 _ ");
        send_byte(CHR_NUL);
        wait_drained();
    endtask

    // receiver holds off long enough for the queue to fill and the input to stall
    task automatic test_backpressure();
        hold_requests++;
        send_text("(,);[]{}:=(,);[]{}:=");
        send_byte(CHR_NUL);
        wait_drained();
    endtask

    task automatic test_random(input int target);
        int goal;
        goal = sent_bytes + target;
        while (sent_bytes < goal)
            send_random_text();
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // output side: stall pattern, with a long hold-off on request
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_CYCLES;
            out_stall   <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // scoreboard: each token word taken is matched against the oldest owed one
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall) begin
            if (pending_tokens.size() == 0) begin
                $display("%0t: unexpected token: kind %0d start %0d length %0d last %0d",
                         $time, token_kind, token_start, token_length, last_result);
                mismatches++;
            end else begin
                oldest = pending_tokens.pop_front();
                if (token_kind !== oldest.kind || token_start !== oldest.start ||
                    token_length !== oldest.len || last_result !== oldest.last) begin
                    $display("%0t: token mismatch: expected kind %0d start %0d length %0d last %0d",
                             $time, oldest.kind, oldest.start, oldest.len, oldest.last);
                    $display("%0t:                 actual   kind %0d start %0d length %0d last %0d",
                             $time, token_kind, token_start, token_length, last_result);
                    mismatches++;
                end
            end
        end
    end

    // watchdog: too long with no word moving on either side ends the run
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("%0t: timeout, no word moved for %0d cycles", $time, QUIET_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // test sequence
    initial
    begin
        lex_reset();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sender idles lightly, receiver stalls about half the time
        send_idle_pct = 20;
        recv_idle_pct = 49;
        test_tokens();
        test_errors();
        test_long_words();
        test_backpressure();
        test_random(150);

        // the other way round
        send_idle_pct = 49;
        recv_idle_pct = 20;
        test_random(150);

        // full rate on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(150);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_tokens.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/klt_pkg.sv
hw/rtl/klt_scan.sv
hw/rtl/klt_queue.sv
hw/rtl/keyword_lexer_tokenizer.sv
hw/rtl/klt_checker.sv
bench/tb_keyword_lexer_tokenizer.sv
